@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk_i and disabled while reset is active.
`define PFTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfte assertion failed");

// Implication form of the same check.
`define PFTE_ASSERT_IMP(lbl, ante, cons) \
  `PFTE_ASSERT(lbl, (ante) |-> (cons))

`endif

@@ design/pfte_pkg.sv @@
`default_nettype none

package pfte_pkg;

  // Display and font geometry.
  localparam int COLUMNS    = 128;
  localparam int ROWS       = 32;
  localparam int FONT_WORDS = 4096;
  localparam int PAGES      = (ROWS + 7) / 8;
  localparam int BUF_BYTES  = COLUMNS * PAGES;
  localparam int BUF_AW     = $clog2(BUF_BYTES);
  localparam int FONT_AW    = $clog2(FONT_WORDS);
  localparam int PG_W       = $clog2(PAGES + 1);

  // Printable character range and the leftmost glyph bit.
  localparam int FIRST_CHAR = 32;
  localparam int LAST_CHAR  = 126;
  localparam int GLYPH_MSB  = 15;

  // Configuration register indexes.
  localparam logic CFG_FONT_WIDTH  = 1'b0;
  localparam logic CFG_FONT_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_CURSOR = 3'd1,
    CMD_PIXEL  = 3'd2,
    CMD_CHAR   = 3'd3,
    CMD_SHIFT  = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CH_INIT,
    ST_CH_ROW,
    ST_CH_FWAIT,
    ST_SH_RD,
    ST_SH_WR,
    ST_RD_WAIT,
    ST_FIN
  } state_e;

  // Input beat layout, last field (cmd) in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [8:0]  buffer_index;
    logic [15:0] font_word;
    logic [11:0] font_index;
    logic [7:0]  shift_count;
    logic [7:0]  char_code;
    logic        color;
    logic [7:0]  y_coord;
    logic [7:0]  x_coord;
    logic [2:0]  cmd;
  } item_t;

  // Result beat layout.
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] read_byte;
    logic       status;
  } res_t;

  // Frame buffer byte address of a page and a column.
  function automatic logic [BUF_AW-1:0] fb_index(logic [7:0] page, logic [8:0] col);
    logic [31:0] idx;
    idx = 32'(page) * 32'(COLUMNS) + 32'(col);
    return idx[BUF_AW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/page_framebuffer_text_engine.sv @@
// One command is handled at a time. Each frame buffer read-modify-write goes
// through a read state and then a write state, which sets how long glyph draws
// and shifts take.
// Reset: asynchronous, active low; afterwards a clearing pass writes zero to all
// BUF_BYTES (512) bytes of the frame buffer before the first beat is taken.
`default_nettype none

module page_framebuffer_text_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [5:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd, x_coord, y_coord, color, char_code, shift_count, font_index, font_word,
  // buffer_index, zero pad
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status, read_byte, zero pad
  output logic [15:0]      m_axis_tdata
);

  localparam int BAW = pfte_pkg::BUF_AW;
  localparam int FAW = pfte_pkg::FONT_AW;
  localparam int PGW = pfte_pkg::PG_W;

  pfte_pkg::state_e state_q, state_d;
  pfte_pkg::item_t  item_q, item_d;

  logic [4:0]     font_width_q;
  logic [5:0]     font_height_q;
  logic [7:0]     cur_col_q, cur_col_d;
  logic [7:0]     cur_row_q, cur_row_d;
  logic [BAW:0]   clr_q, clr_d;
  logic           boot_q, boot_d;
  logic [4:0]     c_q, c_d;
  logic [5:0]     r_q, r_d;
  logic [FAW-1:0] faddr_q, faddr_d;
  logic [15:0]    word_q, word_d;
  logic [8:0]     s_q, s_d;
  logic [8:0]     i_q, i_d;
  logic [PGW-1:0] pg_q, pg_d;
  logic           status_q, status_d;
  logic [7:0]     rbyte_q, rbyte_d;
  logic           mvalid_q, mvalid_d;
  pfte_pkg::res_t mdata_q, mdata_d;

  // Memory port controls.
  logic           fb_we, fb_re, ft_we, ft_re;
  logic [BAW-1:0] fb_waddr, fb_raddr;
  logic [7:0]     fb_wdata, fb_rdata;
  logic [FAW-1:0] ft_waddr;
  logic [15:0]    ft_rdata;

  // Pixel position and value for the shared read-modify-write states.
  logic       is_char;
  logic [8:0] pix_x, pix_y;
  logic       pix_on;
  logic [9:0] sh_src;
  logic [12:0] glyph_base;

  assign is_char = (item_q.cmd == pfte_pkg::CMD_CHAR);
  assign pix_x   = is_char ? (9'(cur_col_q) + 9'(c_q)) : 9'(item_q.x_coord);
  assign pix_y   = is_char ? (9'(cur_row_q) + 9'(r_q)) : 9'(item_q.y_coord);
  assign pix_on  = is_char ? !(word_q[pfte_pkg::GLYPH_MSB] ^ item_q.color) : item_q.color;
  assign sh_src  = 10'(i_q) + 10'(s_q);
  assign glyph_base = 13'(7'(item_q.char_code - 8'(pfte_pkg::FIRST_CHAR))) *
                      13'(font_height_q);

  pfte_ram #(.Width(8), .Depth(pfte_pkg::BUF_BYTES)) u_fb (
    .clk_i  (clk_i),
    .we_i   (fb_we),
    .waddr_i(fb_waddr),
    .wdata_i(fb_wdata),
    .re_i   (fb_re),
    .raddr_i(fb_raddr),
    .rdata_o(fb_rdata)
  );

  pfte_ram #(.Width(16), .Depth(pfte_pkg::FONT_WORDS)) u_font (
    .clk_i  (clk_i),
    .we_i   (ft_we),
    .waddr_i(ft_waddr),
    .wdata_i(item_q.font_word),
    .re_i   (ft_re),
    .raddr_i(faddr_q),
    .rdata_o(ft_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfte_pkg::ST_CLEAR: begin
        if (clr_q == (BAW+1)'(pfte_pkg::BUF_BYTES - 1)) begin
          state_d = boot_q ? pfte_pkg::ST_IDLE : pfte_pkg::ST_FIN;
        end
      end
      pfte_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = pfte_pkg::ST_EXEC;
        end
      end
      pfte_pkg::ST_EXEC: begin
        state_d = pfte_pkg::ST_FIN;
        unique case (item_q.cmd)
          pfte_pkg::CMD_PIXEL: begin
            if (pix_x < 9'(pfte_pkg::COLUMNS) && pix_y < 9'(pfte_pkg::ROWS)) begin
              state_d = pfte_pkg::ST_PIX_RD;
            end
          end
          pfte_pkg::CMD_CHAR: begin
            if (item_q.char_code >= 8'(pfte_pkg::FIRST_CHAR) &&
                item_q.char_code <= 8'(pfte_pkg::LAST_CHAR) &&
                9'(cur_col_q) + 9'(font_width_q) <= 9'(pfte_pkg::COLUMNS) &&
                9'(cur_row_q) + 9'(font_height_q) <= 9'(pfte_pkg::ROWS)) begin
              state_d = pfte_pkg::ST_CH_INIT;
            end
          end
          pfte_pkg::CMD_SHIFT: state_d = pfte_pkg::ST_SH_RD;
          pfte_pkg::CMD_CLEAR: state_d = pfte_pkg::ST_CLEAR;
          pfte_pkg::CMD_READ: begin
            if (10'(item_q.buffer_index) < 10'(pfte_pkg::BUF_BYTES)) begin
              state_d = pfte_pkg::ST_RD_WAIT;
            end
          end
          default: state_d = pfte_pkg::ST_FIN;
        endcase
      end
      pfte_pkg::ST_PIX_RD: begin
        if (is_char && c_q == font_width_q) begin
          state_d = pfte_pkg::ST_CH_ROW;
        end else begin
          state_d = pfte_pkg::ST_PIX_WR;
        end
      end
      pfte_pkg::ST_PIX_WR: state_d = is_char ? pfte_pkg::ST_PIX_RD : pfte_pkg::ST_FIN;
      pfte_pkg::ST_CH_INIT: state_d = pfte_pkg::ST_CH_ROW;
      pfte_pkg::ST_CH_ROW: begin
        state_d = (r_q == font_height_q) ? pfte_pkg::ST_FIN : pfte_pkg::ST_CH_FWAIT;
      end
      pfte_pkg::ST_CH_FWAIT: state_d = pfte_pkg::ST_PIX_RD;
      pfte_pkg::ST_SH_RD: begin
        state_d = (pg_q == PGW'(pfte_pkg::PAGES)) ? pfte_pkg::ST_FIN : pfte_pkg::ST_SH_WR;
      end
      pfte_pkg::ST_SH_WR: state_d = pfte_pkg::ST_SH_RD;
      pfte_pkg::ST_RD_WAIT: state_d = pfte_pkg::ST_FIN;
      pfte_pkg::ST_FIN: begin
        if (!mvalid_q || m_axis_tready) begin
          state_d = pfte_pkg::ST_IDLE;
        end
      end
      default: state_d = pfte_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and memory controls.
  always_comb begin
    item_d    = item_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    clr_d     = clr_q;
    boot_d    = boot_q;
    c_d       = c_q;
    r_d       = r_q;
    faddr_d   = faddr_q;
    word_d    = word_q;
    s_d       = s_q;
    i_d       = i_q;
    pg_d      = pg_q;
    status_d  = status_q;
    rbyte_d   = rbyte_q;
    fb_we     = 1'b0;
    fb_re     = 1'b0;
    fb_waddr  = '0;
    fb_raddr  = '0;
    fb_wdata  = '0;
    ft_we     = 1'b0;
    ft_re     = 1'b0;
    ft_waddr  = item_q.font_index[FAW-1:0];
    s_axis_tready = 1'b0;
    mvalid_d  = mvalid_q && !m_axis_tready;
    mdata_d   = mdata_q;

    unique case (state_q)
      pfte_pkg::ST_CLEAR: begin
        fb_we    = 1'b1;
        fb_waddr = clr_q[BAW-1:0];
        clr_d    = clr_q + 1'b1;
        if (clr_q == (BAW+1)'(pfte_pkg::BUF_BYTES - 1)) begin
          clr_d  = '0;
          boot_d = 1'b0;
        end
      end
      pfte_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        item_d   = pfte_pkg::item_t'(s_axis_tdata);
        status_d = 1'b0;
        rbyte_d  = '0;
      end
      pfte_pkg::ST_EXEC: begin
        status_d = 1'b1;
        unique case (item_q.cmd)
          pfte_pkg::CMD_LOAD: begin
            if (13'(item_q.font_index) < 13'(pfte_pkg::FONT_WORDS)) begin
              ft_we    = 1'b1;
              status_d = 1'b0;
            end
          end
          pfte_pkg::CMD_CURSOR: begin
            cur_col_d = item_q.x_coord;
            cur_row_d = item_q.y_coord;
            status_d  = 1'b0;
          end
          pfte_pkg::CMD_PIXEL: begin
            if (pix_x < 9'(pfte_pkg::COLUMNS) && pix_y < 9'(pfte_pkg::ROWS)) begin
              status_d = 1'b0;
            end
          end
          pfte_pkg::CMD_CHAR: begin
            if (item_q.char_code >= 8'(pfte_pkg::FIRST_CHAR) &&
                item_q.char_code <= 8'(pfte_pkg::LAST_CHAR) &&
                9'(cur_col_q) + 9'(font_width_q) <= 9'(pfte_pkg::COLUMNS) &&
                9'(cur_row_q) + 9'(font_height_q) <= 9'(pfte_pkg::ROWS)) begin
              status_d = 1'b0;
            end
          end
          pfte_pkg::CMD_SHIFT: begin
            status_d = 1'b0;
            s_d  = (9'(item_q.shift_count) > 9'(pfte_pkg::COLUMNS)) ?
                   9'(pfte_pkg::COLUMNS) : 9'(item_q.shift_count);
            i_d  = '0;
            pg_d = '0;
          end
          pfte_pkg::CMD_CLEAR: begin
            status_d = 1'b0;
            clr_d    = '0;
          end
          pfte_pkg::CMD_READ: begin
            if (10'(item_q.buffer_index) < 10'(pfte_pkg::BUF_BYTES)) begin
              fb_re    = 1'b1;
              fb_raddr = item_q.buffer_index[BAW-1:0];
              status_d = 1'b0;
            end
          end
          default: status_d = 1'b1;
        endcase
      end
      pfte_pkg::ST_PIX_RD: begin
        if (is_char && c_q == font_width_q) begin
          r_d     = r_q + 1'b1;
          faddr_d = faddr_q + 1'b1;
        end else begin
          fb_re    = 1'b1;
          fb_raddr = pfte_pkg::fb_index(8'(pix_y[8:3]), pix_x);
        end
      end
      pfte_pkg::ST_PIX_WR: begin
        // Read-modify-write of the one addressed bit.
        fb_we    = 1'b1;
        fb_waddr = pfte_pkg::fb_index(8'(pix_y[8:3]), pix_x);
        fb_wdata = fb_rdata;
        fb_wdata[pix_y[2:0]] = pix_on;
        c_d    = c_q + 1'b1;
        word_d = {word_q[14:0], 1'b0};
      end
      pfte_pkg::ST_CH_INIT: begin
        // The glyph address wraps at the font depth.
        faddr_d = glyph_base[FAW-1:0];
        r_d     = '0;
      end
      pfte_pkg::ST_CH_ROW: begin
        if (r_q == font_height_q) begin
          cur_col_d = cur_col_q + 8'(font_width_q);
        end else begin
          ft_re = 1'b1;
        end
      end
      pfte_pkg::ST_CH_FWAIT: begin
        word_d = ft_rdata;
        c_d    = '0;
      end
      pfte_pkg::ST_SH_RD: begin
        if (pg_q != PGW'(pfte_pkg::PAGES) && sh_src < 10'(pfte_pkg::COLUMNS)) begin
          fb_re    = 1'b1;
          fb_raddr = pfte_pkg::fb_index(8'(pg_q), sh_src[8:0]);
        end
      end
      pfte_pkg::ST_SH_WR: begin
        // Columns with no source left become blank.
        fb_we    = 1'b1;
        fb_waddr = pfte_pkg::fb_index(8'(pg_q), i_q);
        fb_wdata = (sh_src < 10'(pfte_pkg::COLUMNS)) ? fb_rdata : 8'd0;
        if (i_q == 9'(pfte_pkg::COLUMNS - 1)) begin
          i_d  = '0;
          pg_d = pg_q + 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      pfte_pkg::ST_RD_WAIT: rbyte_d = fb_rdata;
      pfte_pkg::ST_FIN: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d          = 1'b1;
          mdata_d           = '0;
          mdata_d.status    = status_q;
          mdata_d.read_byte = rbyte_q;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pfte_pkg::ST_CLEAR;
      clr_q         <= '0;
      boot_q        <= 1'b1;
      mvalid_q      <= 1'b0;
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      font_width_q  <= 5'd7;
      font_height_q <= 6'd10;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      boot_q    <= boot_d;
      mvalid_q  <= mvalid_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      if (cfg_we_i && cfg_idx_i == pfte_pkg::CFG_FONT_WIDTH) begin
        font_width_q <= cfg_data_i[4:0];
      end
      if (cfg_we_i && cfg_idx_i == pfte_pkg::CFG_FONT_HEIGHT) begin
        font_height_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    c_q      <= c_d;
    r_q      <= r_d;
    faddr_q  <= faddr_d;
    word_q   <= word_d;
    s_q      <= s_d;
    i_q      <= i_d;
    pg_q     <= pg_d;
    status_q <= status_d;
    rbyte_q  <= rbyte_d;
    mdata_q  <= mdata_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

endmodule

`default_nettype wire

@@ design/pfte_ram.sv @@
`default_nettype none

module pfte_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/pfte_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module pfte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled result beat stays put.
  `PFTE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  // One command at a time: after taking a beat the input side closes.
  `PFTE_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // A rejected command never returns buffer data.
  `PFTE_ASSERT_IMP(a_reject_zero, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[8:1] == 8'd0)
  // The pad bits of a result are zero.
  `PFTE_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0)

endmodule

bind page_framebuffer_text_engine pfte_checker u_pfte_checker (.*);

`default_nettype wire

@@ sim/page_framebuffer_text_engine_test.sv @@
`timescale 1ns / 1ps

module page_framebuffer_text_engine_test;

  // Code with no command behind it; the block must reject it.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int MAX_REPORTS = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = pfte_pkg::CFG_FONT_WIDTH;
  logic [5:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  page_framebuffer_text_engine dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the display state.
  logic [7:0]  fb_mem [pfte_pkg::BUF_BYTES];
  logic [15:0] glyph_mem [pfte_pkg::FONT_WORDS];
  bit          glyph_known [pfte_pkg::FONT_WORDS];
  logic [7:0]  cur_col, cur_row;
  logic [4:0]  glyph_w;
  logic [5:0]  glyph_h;

  pfte_pkg::res_t pending_results[$];
  int   mismatches = 0;
  int   beats_sent = 0;
  int   beats_checked = 0;
  int   glyphs_drawn = 0;
  int   rejects_seen = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_request = 0;
  int   hold_left = 0;

  function automatic bit plot(int x, int y, logic white);
    int idx;
    if (x >= pfte_pkg::COLUMNS || y >= pfte_pkg::ROWS) return 1'b0;
    idx = x + (y / 8) * pfte_pkg::COLUMNS;
    fb_mem[idx][y % 8] = white;
    return 1'b1;
  endfunction

  // True when a draw gets past the code and fit checks and reads font words.
  function automatic bit glyph_fits(logic [7:0] code);
    if (code < pfte_pkg::FIRST_CHAR || code > pfte_pkg::LAST_CHAR) return 1'b0;
    return int'(cur_col) + int'(glyph_w) <= pfte_pkg::COLUMNS &&
           int'(cur_row) + int'(glyph_h) <= pfte_pkg::ROWS;
  endfunction

  function automatic int glyph_addr(logic [7:0] code, int r);
    return ((int'(code) - pfte_pkg::FIRST_CHAR) * int'(glyph_h) + r) % pfte_pkg::FONT_WORDS;
  endfunction

  function automatic bit draw_glyph(logic [7:0] code, logic white);
    logic [15:0] bits;
    bit on;
    if (!glyph_fits(code)) return 1'b0;
    for (int r = 0; r < int'(glyph_h); r++) begin
      bits = glyph_mem[glyph_addr(code, r)];
      for (int c = 0; c < int'(glyph_w); c++) begin
        on = c < 16 && bits[15 - c];
        void'(plot(int'(cur_col) + c, int'(cur_row) + r, on ? white : !white));
      end
    end
    cur_col = cur_col + 8'(glyph_w);
    return 1'b1;
  endfunction

  // Applies one command to the local state and returns the result it gives.
  function automatic pfte_pkg::res_t apply_cmd(pfte_pkg::item_t it);
    pfte_pkg::res_t r;
    int s;
    r = '0;
    case (it.cmd)
      pfte_pkg::CMD_LOAD: begin
        glyph_mem[it.font_index] = it.font_word;
        glyph_known[it.font_index] = 1'b1;
      end
      pfte_pkg::CMD_CURSOR: begin
        cur_col = it.x_coord;
        cur_row = it.y_coord;
      end
      pfte_pkg::CMD_PIXEL: r.status = !plot(int'(it.x_coord), int'(it.y_coord), it.color);
      pfte_pkg::CMD_CHAR: r.status = !draw_glyph(it.char_code, it.color);
      pfte_pkg::CMD_SHIFT: begin
        s = (int'(it.shift_count) > pfte_pkg::COLUMNS) ? pfte_pkg::COLUMNS :
            int'(it.shift_count);
        for (int p = 0; p < pfte_pkg::PAGES; p++)
          for (int i = 0; i < pfte_pkg::COLUMNS; i++)
            fb_mem[p * pfte_pkg::COLUMNS + i] = (i + s < pfte_pkg::COLUMNS) ?
                fb_mem[p * pfte_pkg::COLUMNS + i + s] : 8'h00;
      end
      pfte_pkg::CMD_CLEAR: foreach (fb_mem[i]) fb_mem[i] = 8'h00;
      pfte_pkg::CMD_READ: begin
        if (int'(it.buffer_index) < pfte_pkg::BUF_BYTES) r.read_byte = fb_mem[it.buffer_index];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // Sends one command beat, with an optional random gap before it.
  task automatic send_cmd(pfte_pkg::item_t it);
    pfte_pkg::res_t r;
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    it.pad = '0;
    s_axis_tdata  <= it;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_cmd(it);
    if (it.cmd == pfte_pkg::CMD_CHAR && !r.status) glyphs_drawn++;
    pending_results.push_back(r);
    beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic pfte_pkg::item_t noise_item();
    pfte_pkg::item_t it;
    it = pfte_pkg::item_t'(80'({$urandom, $urandom, $urandom}));
    it.pad = '0;
    return it;
  endfunction

  task automatic send_op(logic [2:0] cmd, int a = 0, int b = 0, logic color = 1'b1);
    pfte_pkg::item_t it;
    it = noise_item();
    it.cmd = cmd;
    case (cmd)
      pfte_pkg::CMD_LOAD: begin it.font_index = 12'(a); it.font_word = 16'(b); end
      pfte_pkg::CMD_CURSOR, pfte_pkg::CMD_PIXEL: begin
        it.x_coord = 8'(a);
        it.y_coord = 8'(b);
      end
      pfte_pkg::CMD_CHAR: it.char_code = 8'(a);
      pfte_pkg::CMD_SHIFT: it.shift_count = 8'(a);
      pfte_pkg::CMD_READ: it.buffer_index = 9'(a);
      default: ;
    endcase
    it.color = color;
    send_cmd(it);
  endtask

  // A glyph may only read font words that were loaded since reset.
  task automatic draw_char(logic [7:0] code, logic color);
    int a;
    if (glyph_fits(code))
      for (int r = 0; r < int'(glyph_h); r++) begin
        a = glyph_addr(code, r);
        if (!glyph_known[a]) send_op(pfte_pkg::CMD_LOAD, a, int'($urandom_range(16'hFFFF)));
      end
    send_op(pfte_pkg::CMD_CHAR, int'(code), 0, color);
  endtask

  // The input side goes quiet first, so no beat is taken twice.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_font(int w, int h);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pfte_pkg::CFG_FONT_WIDTH;
    cfg_data_i <= 6'(w);
    @(negedge clk_i);
    cfg_idx_i  <= pfte_pkg::CFG_FONT_HEIGHT;
    cfg_data_i <= 6'(h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    glyph_w = 5'(w);
    glyph_h = 6'(h);
  endtask

  // One random command, mostly well-formed so that glyphs really get drawn.
  // Draws mostly use a small set of codes so that few font words need loading.
  task automatic send_random();
    pfte_pkg::item_t it;
    int pick;
    logic [7:0] code;
    it = noise_item();
    pick = $urandom_range(99);
    if (pick < 30) begin
      code = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
             8'(pfte_pkg::FIRST_CHAR + $urandom_range(7));
      draw_char(code, 1'($urandom_range(1)));
      return;
    end
    if (pick < 40) begin
      it.cmd = pfte_pkg::CMD_LOAD;
    end else if (pick < 55) begin
      it.cmd = pfte_pkg::CMD_CURSOR;
      if ($urandom_range(4) != 0) begin
        it.x_coord = 8'($urandom_range(pfte_pkg::COLUMNS - 1));
        it.y_coord = 8'($urandom_range(pfte_pkg::ROWS - 1));
      end
    end else if (pick < 73) begin
      it.cmd = pfte_pkg::CMD_PIXEL;
      if ($urandom_range(6) != 0) begin
        it.x_coord = 8'($urandom_range(pfte_pkg::COLUMNS - 1));
        it.y_coord = 8'($urandom_range(pfte_pkg::ROWS - 1));
      end
    end else if (pick < 76) begin
      it.cmd = pfte_pkg::CMD_SHIFT;
      if ($urandom_range(2) != 0) it.shift_count = 8'($urandom_range(3));
    end else if (pick < 77) begin
      it.cmd = pfte_pkg::CMD_CLEAR;
    end else if (pick < 98) begin
      it.cmd = pfte_pkg::CMD_READ;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    send_cmd(it);
  endtask

  // Field extremes, every command and the corner cases, with the reset font.
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_op(pfte_pkg::CMD_LOAD, 0, 16'hFFFF);
    send_op(pfte_pkg::CMD_LOAD, pfte_pkg::FONT_WORDS - 1, 16'h0000);
    send_op(pfte_pkg::CMD_PIXEL, 0, 0, 1'b1);
    send_op(pfte_pkg::CMD_PIXEL, pfte_pkg::COLUMNS - 1, pfte_pkg::ROWS - 1, 1'b1);
    send_op(pfte_pkg::CMD_PIXEL, pfte_pkg::COLUMNS, 0);
    send_op(pfte_pkg::CMD_PIXEL, 0, pfte_pkg::ROWS);
    send_op(pfte_pkg::CMD_PIXEL, 255, 255);
    send_op(pfte_pkg::CMD_READ, 0);
    send_op(pfte_pkg::CMD_READ, pfte_pkg::BUF_BYTES - 1);
    send_op(pfte_pkg::CMD_PIXEL, 0, 0, 1'b0);
    send_op(pfte_pkg::CMD_CHAR, pfte_pkg::FIRST_CHAR - 1);
    send_op(pfte_pkg::CMD_CHAR, pfte_pkg::LAST_CHAR + 1);
    send_op(pfte_pkg::CMD_CHAR, 0);
    send_op(pfte_pkg::CMD_CHAR, 255);
    send_op(pfte_pkg::CMD_CURSOR, 255, 255);
    draw_char(8'(pfte_pkg::LAST_CHAR), 1'b1);
    send_op(pfte_pkg::CMD_CURSOR, pfte_pkg::COLUMNS - 7, pfte_pkg::ROWS - 10);
    draw_char(8'(pfte_pkg::FIRST_CHAR), 1'b1);
    send_op(pfte_pkg::CMD_READ, 3 * pfte_pkg::COLUMNS + pfte_pkg::COLUMNS - 1);
    send_op(pfte_pkg::CMD_SHIFT, 0);
    send_op(pfte_pkg::CMD_SHIFT, 1);
    send_op(pfte_pkg::CMD_SHIFT, 255);
    send_op(pfte_pkg::CMD_CLEAR);
    send_op(CMD_UNUSED);
    send_op(pfte_pkg::CMD_READ, pfte_pkg::COLUMNS + 5);
  endtask

  // Glyph geometry across the register range, zero and oversize included.
  task automatic test_font_geometry();
    int sizes[6][2] = '{'{0, 0}, '{31, 63}, '{1, 1}, '{16, 32}, '{17, 8}, '{31, 4}};
    foreach (sizes[i]) begin
      set_font(sizes[i][0], sizes[i][1]);
      send_op(pfte_pkg::CMD_CURSOR, 0, 0);
      repeat (3) draw_char(8'($urandom_range(pfte_pkg::LAST_CHAR, pfte_pkg::FIRST_CHAR)),
                           1'($urandom_range(1)));
      send_op(pfte_pkg::CMD_CURSOR, pfte_pkg::COLUMNS - sizes[i][0],
              pfte_pkg::ROWS - sizes[i][1]);
      draw_char(8'(pfte_pkg::LAST_CHAR), 1'b0);
      repeat (4) send_op(pfte_pkg::CMD_READ, int'($urandom_range(pfte_pkg::BUF_BYTES - 1)));
    end
  endtask

  // Random traffic under each idle and stall pattern, with a new glyph size per phase.
  task automatic test_random_traffic();
    int idles[4] = '{0, 68, 0, 9};
    int stalls[4] = '{0, 0, 68, 9};
    for (int ph = 0; ph < 4; ph++) begin
      set_font(int'($urandom_range(16, 1)), int'($urandom_range(12, 1)));
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      repeat (170) send_random();
    end
  endtask

  // The receiver holds off while commands keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_drained();
    set_font(7, 10);
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 600;
    repeat (40) send_random();
  endtask

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    pfte_pkg::res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pfte_pkg::res_t'(m_axis_tdata);
      beats_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: status %0d read_byte %02h", got.status, got.read_byte);
      end else begin
        want = pending_results.pop_front();
        if (got.status) rejects_seen++;
        if (got.status !== want.status || got.read_byte !== want.read_byte) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected status %0d read_byte %02h, got status %0d read_byte %02h",
                     beats_checked, want.status, want.read_byte, got.status, got.read_byte);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL page_framebuffer_text_engine");
    $finish;
  end

  initial begin
    foreach (fb_mem[i]) fb_mem[i] = 8'h00;
    foreach (glyph_mem[i]) glyph_mem[i] = 16'h0000;
    cur_col = '0;
    cur_row = '0;
    glyph_w = 5'd7;
    glyph_h = 6'd10;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_font_geometry();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d commands and checked %0d results, %0d of them rejects.",
             beats_sent, beats_checked, rejects_seen);
    $display("Drew %0d glyphs over several font sizes and idle patterns; %0d mismatches.",
             glyphs_drawn, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS page_framebuffer_text_engine");
    end else begin
      $display("FAIL page_framebuffer_text_engine");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/pfte_pkg.sv
design/pfte_ram.sv
design/page_framebuffer_text_engine.sv
design/pfte_checker.sv
sim/page_framebuffer_text_engine_test.sv
